// ===== src/bgps_pkg.sv =====
`default_nettype none

package bgps_pkg;

    // Sizing limits of the block.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_BLOCK  = 32;
    localparam int GRAD_BITS  = 16;

    // Derived widths.
    localparam int XW    = $clog2(MAX_WIDTH);                 // pixel coordinate
    localparam int DIMW  = XW + 1;                            // clamped image dimension
    localparam int BW    = $clog2(MAX_BLOCK + 1);             // clamped block side
    localparam int CW    = $clog2(MAX_BLOCK);                 // position inside a block
    localparam int OFFW  = 2 * CW;                            // raster offset inside a block
    localparam int BBW   = $clog2(MAX_BLOCK * MAX_BLOCK + 1); // block area
    localparam int SUMW  = GRAD_BITS + OFFW;                  // block gradient sum
    localparam int PRODW = GRAD_BITS + BBW;                   // value times block area

    // Register field widths and the APB port.
    localparam int BSW    = 6;
    localparam int THRW   = 16;
    localparam int IMGW   = 12;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [BW-1:0]   b;
        logic [THRW-1:0] thr;
        logic [DIMW-1:0] w;
        logic [DIMW-1:0] h;
    } t_cfg;

    // One in-block pixel handed from the front to the back.
    typedef struct packed {
        logic [XW-1:0]        bi;
        logic [GRAD_BITS-1:0] grad;
        logic [OFFW-1:0]      off;
        logic                 is_first;
        logic                 is_last;
        logic [XW-1:0]        bx0;
        logic [XW-1:0]        by0;
    } t_task;

    typedef struct packed {
        logic [XW-1:0]        x;
        logic [XW-1:0]        y;
        logic [GRAD_BITS-1:0] peak;
    } t_result;

    // One step of restoring division by the block side.
    // Returns the quotient bit above the new remainder.
    function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
                                             input logic          din,
                                             input logic [BW-1:0] b);
        logic [BW:0] t;
        logic [BW:0] d;
        t = (BW + 1)'({rem, din});
        d = t - (BW + 1)'(b);
        if (t >= (BW + 1)'(b)) begin
            return {1'b1, d[CW-1:0]};
        end
        return {1'b0, t[CW-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== src/block_gradient_peak_select_top.sv =====
// Block gradient peak selection.
// Gradient magnitudes enter one pixel per transfer in raster order on the
// pixel channel (i_pix_valid / o_pix_ready); i_frame_start marks the first
// pixel of a frame. The image is tiled into square blocks of block_size
// pixels; at the last pixel of each complete block that ends short of the
// right and bottom edges the strongest pixel is offered on the candidate
// channel (o_cand_valid / i_cand_ready) when it beats the block mean by
// grad_threshold. Partial blocks and blocks ending at an edge give nothing.
// Throughput is one pixel per clock while o_pix_ready is high. After its
// block's last pixel is transferred, a candidate passes the 4-entry queue,
// the block accumulator read-modify-write, two compare stages, a 10-stage
// divider that turns the stored raster offset back into coordinates, and
// the buffer write. Writing block_size makes the pixel channel drop ready
// while the position counters are re-derived for the new size, one bit a cycle.
// Reset clears the position to the start of a frame and loads the register
// defaults (8, 256, 640, 480); the block accumulators hold no reset value.
// A stalled receiver fills a 16-entry candidate buffer; pixels keep flowing
// until block ends can no longer reserve a slot, then ready drops.
`default_nettype none

module block_gradient_peak_select_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgps_pkg::APB_AW-1:0]       paddr,
    input  logic [bgps_pkg::APB_DW-1:0]       pwdata,
    output logic [bgps_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // Pixel channel.
    input  logic                              i_pix_valid,
    output logic                              o_pix_ready,
    input  logic [bgps_pkg::GRAD_BITS-1:0]    i_gradient,
    input  logic                              i_frame_start,
    // Candidate channel.
    output logic                              o_cand_valid,
    input  logic                              i_cand_ready,
    output logic [bgps_pkg::XW-1:0]           o_candidate_x,
    output logic [bgps_pkg::XW-1:0]           o_candidate_y,
    output logic [bgps_pkg::GRAD_BITS-1:0]    o_peak_value
);
    import bgps_pkg::*;

    localparam int RIW = APB_AW - 2;

    typedef enum logic [RIW-1:0] {
        REG_BLOCK_SIZE     = RIW'(0),
        REG_GRAD_THRESHOLD = RIW'(1),
        REG_IMAGE_WIDTH    = RIW'(2),
        REG_IMAGE_HEIGHT   = RIW'(3)
    } t_reg_idx;

    logic [BSW-1:0]  r_block_size;
    logic [THRW-1:0] r_grad_threshold;
    logic [IMGW-1:0] r_image_width;
    logic [IMGW-1:0] r_image_height;

    t_reg_idx reg_idx;
    logic     cfg_write;
    logic     resync;
    t_cfg     cfg;

    logic    q_full, q_push, q_pop, q_head_valid;
    t_task   q_push_task, q_head;
    t_result result;

    // Registers sit at byte offsets 4*i; the low address bits are ignored.
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign resync    = cfg_write && (reg_idx == REG_BLOCK_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size     <= BSW'(8);
            r_grad_threshold <= THRW'(256);
            r_image_width    <= IMGW'(640);
            r_image_height   <= IMGW'(480);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_BLOCK_SIZE:     r_block_size     <= pwdata[BSW-1:0];
                REG_GRAD_THRESHOLD: r_grad_threshold <= pwdata[THRW-1:0];
                REG_IMAGE_WIDTH:    r_image_width    <= pwdata[IMGW-1:0];
                REG_IMAGE_HEIGHT:   r_image_height   <= pwdata[IMGW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BLOCK_SIZE:     prdata = APB_DW'(r_block_size);
            REG_GRAD_THRESHOLD: prdata = APB_DW'(r_grad_threshold);
            REG_IMAGE_WIDTH:    prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT:   prdata = APB_DW'(r_image_height);
            default:            prdata = '0;
        endcase
    end

    // Out-of-range settings are pulled into range: zero acts as one, and
    // anything above the supported limit saturates at the limit.
    always_comb begin
        if (r_block_size == '0) begin
            cfg.b = BW'(1);
        end else if (int'(r_block_size) > MAX_BLOCK) begin
            cfg.b = BW'(MAX_BLOCK);
        end else begin
            cfg.b = BW'(r_block_size);
        end

        cfg.thr = r_grad_threshold;

        if (r_image_width == '0) begin
            cfg.w = DIMW'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            cfg.w = DIMW'(MAX_WIDTH);
        end else begin
            cfg.w = DIMW'(r_image_width);
        end

        if (r_image_height == '0) begin
            cfg.h = DIMW'(1);
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            cfg.h = DIMW'(MAX_HEIGHT);
        end else begin
            cfg.h = DIMW'(r_image_height);
        end
    end

    // The front tracks the raster position and passes on only pixels inside a
    // complete block that ends short of the right and bottom edges to the queue.
    bgps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_resync      (resync),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_gradient    (i_gradient),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_task      (q_push_task)
    );

    bgps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_task  (q_push_task),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // The back owns the per-block accumulators, the threshold test and the
    // candidate buffer.
    bgps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_cand_valid (o_cand_valid),
        .i_cand_ready (i_cand_ready),
        .o_result     (result)
    );

    assign o_candidate_x = result.x;
    assign o_candidate_y = result.y;
    assign o_peak_value  = result.peak;

endmodule

`default_nettype wire

// ===== src/bgps_front.sv =====
`default_nettype none

module bgps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bgps_pkg::t_cfg                 i_cfg,
    input  logic                           i_resync,
    input  logic                           i_pix_valid,
    output logic                           o_pix_ready,
    input  logic [bgps_pkg::GRAD_BITS-1:0] i_gradient,
    input  logic                           i_frame_start,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output bgps_pkg::t_task                o_q_task
);
    import bgps_pkg::*;

    localparam int STW = $clog2(XW + 1);

    typedef enum logic [1:0] {
        FS_RUN  = 2'b01,
        FS_SYNC = 2'b10
    } t_fstate;

    t_fstate       r_state, n_state;
    logic [XW-1:0] r_x, n_x, r_y, n_y, r_bi, n_bi, r_bx0, n_bx0, r_by0, n_by0;
    logic [CW-1:0] r_col, n_col, r_row, n_row;
    logic [STW-1:0] r_step, n_step;
    logic [XW-1:0] r_dx, n_dx, r_dy, n_dy, r_qx, n_qx;
    logic [CW-1:0] r_rx, n_rx, r_ry, n_ry;

    logic [XW-1:0]   c_x, c_y, c_bi, c_bx0, c_by0;
    logic [CW-1:0]   c_col, c_row;
    logic [DIMW-1:0] c_xspan, c_yspan;
    logic            c_in_block, c_col_end, c_row_end, c_x_wrap, c_y_wrap;
    logic [CW+BW:0]  c_off_full;
    logic [OFFW-1:0] c_off;
    logic            accept;
    logic [CW:0]     sx, sy;

    assign o_pix_ready = (r_state == FS_RUN) && !i_q_full;
    assign accept      = i_pix_valid && o_pix_ready;

    // Classification of the offered pixel. A frame start forces position zero.
    always_comb begin
        c_x   = i_frame_start ? '0 : r_x;
        c_y   = i_frame_start ? '0 : r_y;
        c_bi  = i_frame_start ? '0 : r_bi;
        c_col = i_frame_start ? '0 : r_col;
        c_row = i_frame_start ? '0 : r_row;
        c_bx0 = i_frame_start ? '0 : r_bx0;
        c_by0 = i_frame_start ? '0 : r_by0;

        c_xspan    = DIMW'(c_bx0) + DIMW'(i_cfg.b);
        c_yspan    = DIMW'(c_by0) + DIMW'(i_cfg.b);
        c_in_block = (c_xspan < i_cfg.w) && (c_yspan < i_cfg.h);

        c_off_full = (CW + BW + 1)'(c_row) * (CW + BW + 1)'(i_cfg.b) + (CW + BW + 1)'(c_col);
        c_off      = c_off_full[OFFW-1:0];
        c_col_end  = (BW'(c_col) == i_cfg.b - BW'(1));
        c_row_end  = (BW'(c_row) == i_cfg.b - BW'(1));
        c_x_wrap   = (DIMW'(c_x) + DIMW'(1)) >= i_cfg.w;
        c_y_wrap   = (DIMW'(c_y) + DIMW'(1)) >= i_cfg.h;

        o_q_push          = accept && c_in_block;
        o_q_task.bi       = c_bi;
        o_q_task.grad     = i_gradient;
        o_q_task.off      = c_off;
        o_q_task.is_first = (c_off == '0);
        o_q_task.is_last  = c_col_end && c_row_end;
        o_q_task.bx0      = c_bx0;
        o_q_task.by0      = c_by0;
    end

    always_comb begin
        sx = div_step(r_rx, r_dx[XW-1], i_cfg.b);
        sy = div_step(r_ry, r_dy[XW-1], i_cfg.b);

        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_bi    = r_bi;
        n_col   = r_col;
        n_row   = r_row;
        n_bx0   = r_bx0;
        n_by0   = r_by0;
        n_step  = r_step;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_qx    = r_qx;
        n_rx    = r_rx;
        n_ry    = r_ry;

        unique case (r_state)
            FS_RUN: begin
                if (accept) begin
                    if (c_x_wrap) begin
                        n_x   = '0;
                        n_col = '0;
                        n_bi  = '0;
                        n_bx0 = '0;
                        if (c_y_wrap) begin
                            n_y   = '0;
                            n_row = '0;
                            n_by0 = '0;
                        end else begin
                            n_y = c_y + XW'(1);
                            if (c_row_end) begin
                                n_row = '0;
                                n_by0 = c_by0 + XW'(i_cfg.b);
                            end else begin
                                n_row = c_row + CW'(1);
                                n_by0 = c_by0;
                            end
                        end
                    end else begin
                        n_x   = c_x + XW'(1);
                        n_y   = c_y;
                        n_row = c_row;
                        n_by0 = c_by0;
                        if (c_col_end) begin
                            n_col = '0;
                            n_bi  = c_bi + XW'(1);
                            n_bx0 = c_bx0 + XW'(i_cfg.b);
                        end else begin
                            n_col = c_col + CW'(1);
                            n_bi  = c_bi;
                            n_bx0 = c_bx0;
                        end
                    end
                end
            end
            FS_SYNC: begin
                // Re-derive the block counters from the position, one bit a cycle.
                n_rx   = sx[CW-1:0];
                n_qx   = {r_qx[XW-2:0], sx[CW]};
                n_dx   = r_dx << 1;
                n_ry   = sy[CW-1:0];
                n_dy   = r_dy << 1;
                n_step = r_step - STW'(1);
                if (r_step == STW'(1)) begin
                    n_state = FS_RUN;
                    n_col   = sx[CW-1:0];
                    n_bi    = {r_qx[XW-2:0], sx[CW]};
                    n_bx0   = r_x - XW'(sx[CW-1:0]);
                    n_row   = sy[CW-1:0];
                    n_by0   = r_y - XW'(sy[CW-1:0]);
                end
            end
            default: n_state = FS_RUN;
        endcase

        if (i_resync) begin
            n_state = FS_SYNC;
            n_step  = STW'(XW);
            n_dx    = r_x;
            n_dy    = r_y;
            n_rx    = '0;
            n_ry    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_RUN;
            r_x     <= '0;
            r_y     <= '0;
            r_bi    <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_bx0   <= '0;
            r_by0   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_bi    <= n_bi;
            r_col   <= n_col;
            r_row   <= n_row;
            r_bx0   <= n_bx0;
            r_by0   <= n_by0;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_qx <= n_qx;
        r_rx <= n_rx;
        r_ry <= n_ry;
    end

endmodule

`default_nettype wire

// ===== src/bgps_queue.sv =====
`default_nettype none

module bgps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bgps_pkg::t_task i_push_task,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output bgps_pkg::t_task o_head
);
    import bgps_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    t_task          r_mem [QDEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QPW:0]   r_cnt, n_cnt;

    assign o_full       = (r_cnt == (QPW + 1)'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign n_cnt        = r_cnt + (QPW + 1)'(i_push) - (QPW + 1)'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + QPW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + QPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_task;
        end
    end

endmodule

`default_nettype wire

// ===== src/bgps_back.sv =====
`default_nettype none

module bgps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgps_pkg::t_cfg    i_cfg,
    input  logic              i_head_valid,
    input  bgps_pkg::t_task   i_head,
    output logic              o_pop,
    output logic              o_cand_valid,
    input  logic              i_cand_ready,
    output bgps_pkg::t_result o_result
);
    import bgps_pkg::*;

    localparam int ODEPTH = 16;
    localparam int OPW    = $clog2(ODEPTH);
    localparam int CRW    = OPW + 1;

    typedef struct packed {
        logic [SUMW-1:0]      sum;
        logic [GRAD_BITS-1:0] peak;
        logic [OFFW-1:0]      off;
    } t_entry;

    typedef struct packed {
        logic [CW-1:0]        rem;
        logic [OFFW-1:0]      num;
        logic [XW-1:0]        bx0;
        logic [XW-1:0]        by0;
        logic [GRAD_BITS-1:0] peak;
    } t_dstage;

    // Per-block accumulators of the current block row.
    t_entry        r_blk [MAX_WIDTH];
    t_entry        r_rd, r_lw, b_base, b_new;
    logic [XW-1:0] r_lw_bi;
    logic          r_lw_valid;

    logic  r_b_valid;
    t_task r_b;

    logic          r_c_valid;
    t_entry        r_c_ent;
    logic [XW-1:0] r_c_bx0, r_c_by0;
    logic [BBW-1:0] r_bb;

    logic                 r_d_valid;
    logic [PRODW-1:0]     r_d_lhs, r_d_tbb;
    logic [SUMW-1:0]      r_d_sum;
    logic [OFFW-1:0]      r_d_off;
    logic [XW-1:0]        r_d_bx0, r_d_by0;
    logic [GRAD_BITS-1:0] r_d_peak;
    logic [PRODW:0]       d_rhs;
    logic                 d_pass, d_drop;

    logic    r_dv [OFFW+1];
    t_dstage r_ds [OFFW+1];
    t_dstage ds_next [OFFW];
    logic [CW:0] s_div [OFFW];

    t_result        r_of [ODEPTH];
    t_result        out_data;
    logic [OPW-1:0] r_owp, r_orp;
    logic [OPW:0]   r_ocnt;
    logic           out_push, out_pop;

    logic [CRW-1:0] r_credit;
    logic           can_last;

    // A block end reserves an output slot when it leaves the queue, so the
    // pipeline behind it never has to stall.
    assign can_last = (r_credit < CRW'(ODEPTH));
    assign o_pop    = i_head_valid && (!i_head.is_last || can_last);

    // Read-modify-write of the block entry; the last write is forwarded
    // because the read of the following pixel was issued before it landed.
    always_comb begin
        b_base = (r_lw_valid && (r_lw_bi == r_b.bi)) ? r_lw : r_rd;
        b_new  = b_base;
        if (r_b.is_first) begin
            b_new.sum  = SUMW'(r_b.grad);
            b_new.peak = r_b.grad;
            b_new.off  = '0;
        end else begin
            b_new.sum = b_base.sum + SUMW'(r_b.grad);
            if (r_b.grad > b_base.peak) begin
                b_new.peak = r_b.grad;
                b_new.off  = r_b.off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_blk[r_b.bi] <= b_new;
        end
        r_rd <= r_blk[i_head.bi];
    end

    // Exact form of peak > mean + threshold: peak*B*B > sum + threshold*B*B.
    assign d_rhs  = (PRODW + 1)'(r_d_sum) + (PRODW + 1)'(r_d_tbb);
    assign d_pass = (PRODW + 1)'(r_d_lhs) > d_rhs;
    assign d_drop = r_d_valid && !d_pass;

    always_comb begin
        for (int k = 0; k < OFFW; k++) begin
            s_div[k]       = div_step(r_ds[k].rem, r_ds[k].num[OFFW-1], i_cfg.b);
            ds_next[k]     = r_ds[k];
            ds_next[k].rem = s_div[k][CW-1:0];
            ds_next[k].num = {r_ds[k].num[OFFW-2:0], s_div[k][CW]};
        end
    end

    // After the last step num holds offset / B and rem holds offset % B.
    always_comb begin
        out_data.x    = r_ds[OFFW].bx0 + XW'(r_ds[OFFW].rem);
        out_data.y    = r_ds[OFFW].by0 + XW'(r_ds[OFFW].num);
        out_data.peak = r_ds[OFFW].peak;
    end

    assign out_push     = r_dv[OFFW];
    assign o_cand_valid = (r_ocnt != '0);
    assign out_pop      = o_cand_valid && i_cand_ready;
    assign o_result     = r_of[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
            for (int k = 0; k <= OFFW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
            r_credit <= '0;
        end else begin
            r_lw_valid <= r_lw_valid || r_b_valid;
            r_b_valid  <= o_pop;
            r_c_valid  <= r_b_valid && r_b.is_last;
            r_d_valid  <= r_c_valid;
            r_dv[0]    <= r_d_valid && d_pass;
            for (int k = 0; k < OFFW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ocnt <= r_ocnt + (OPW + 1)'(out_push) - (OPW + 1)'(out_pop);
            if (out_push) begin
                r_owp <= (r_owp == OPW'(ODEPTH - 1)) ? '0 : r_owp + OPW'(1);
            end
            if (out_pop) begin
                r_orp <= (r_orp == OPW'(ODEPTH - 1)) ? '0 : r_orp + OPW'(1);
            end
            r_credit <= r_credit + CRW'(o_pop && i_head.is_last)
                        - CRW'(d_drop) - CRW'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_lw    <= b_new;
            r_lw_bi <= r_b.bi;
        end
        r_b     <= i_head;
        r_c_ent <= b_new;
        r_c_bx0 <= r_b.bx0;
        r_c_by0 <= r_b.by0;
        r_bb    <= BBW'(BBW'(i_cfg.b) * BBW'(i_cfg.b));

        r_d_lhs  <= PRODW'(r_c_ent.peak) * PRODW'(r_bb);
        r_d_tbb  <= PRODW'(i_cfg.thr) * PRODW'(r_bb);
        r_d_sum  <= r_c_ent.sum;
        r_d_off  <= r_c_ent.off;
        r_d_peak <= r_c_ent.peak;
        r_d_bx0  <= r_c_bx0;
        r_d_by0  <= r_c_by0;

        r_ds[0].rem  <= '0;
        r_ds[0].num  <= r_d_off;
        r_ds[0].bx0  <= r_d_bx0;
        r_ds[0].by0  <= r_d_by0;
        r_ds[0].peak <= r_d_peak;
        for (int k = 0; k < OFFW; k++) begin
            r_ds[k+1] <= ds_next[k];
        end

        if (out_push) begin
            r_of[r_owp] <= out_data;
        end
    end

endmodule

`default_nettype wire
